/* sv/swm_pkg.sv */
// Package for the salted word memory: memory geometry and command and size codes.
// It depends on nothing else. The top level and its checker both import it.
package swm_pkg;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned Words = 1 << IdxW;
  localparam int unsigned AddrW = 13;
  localparam int unsigned DataW = 64;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_STORE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_HALF  = 2'd1,
    SIZE_WORD  = 2'd2,
    SIZE_DWORD = 2'd3
  } size_e;

  // This mask covers the low bytes of an access of the given width.
  function automatic logic [DataW-1:0] width_mask(input logic [1:0] size);
    logic [DataW-1:0] m;
    unique case (size)
      SIZE_BYTE: m = 64'h0000_0000_0000_00ff;
      SIZE_HALF: m = 64'h0000_0000_0000_ffff;
      SIZE_WORD: m = 64'h0000_0000_ffff_ffff;
      default:   m = '1;
    endcase
    return m;
  endfunction

endpackage

/* sv/salted_word_memory.sv */
// Top level of the salted word memory: two synchronous memories for the masked
// words and their salts, with a read-modify-write stage and an output register.
// It depends on swm_pkg.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | cmd, byte_addr, access_size,
//           |           |                          | write_data, fresh_salt
//   out     | output    | out_valid_o / out_stall_i| read_data
//
// An item is read from memory in the cycle of its transfer, then unmasked,
// merged and written back once it may finish. Items overlap: the block takes
// one item per cycle (each memory has one read port) unless a load waits on a
// stalled output. Any access to the word the item ahead stores is forwarded.
// Reset clears only the control state; the memories hold nothing defined.
// The input stalls only while a load waits for a stalled, full output register.
module salted_word_memory import swm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [AddrW-1:0] byte_addr_i,
  input  logic [1:0]       access_size_i,
  input  logic [DataW-1:0] write_data_i,
  input  logic [DataW-1:0] fresh_salt_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] read_data_o
);

  logic [DataW-1:0] masked_mem [Words];
  logic [DataW-1:0] salt_mem   [Words];

  logic             busy_q;
  logic             cmd_q;
  logic [IdxW-1:0]  idx_q;
  logic [2:0]       off_q;
  logic [1:0]       size_q;
  logic [DataW-1:0] data_q;
  logic [DataW-1:0] salt_q;
  logic [DataW-1:0] rd_masked_q;
  logic [DataW-1:0] rd_salt_q;
  logic             fwd_q;
  logic             fwd_d;
  logic [DataW-1:0] fwd_word_q;
  logic             out_valid_q;
  logic [DataW-1:0] read_data_q;

  logic             in_accept;
  logic             finish;
  logic             is_store;
  logic [IdxW-1:0]  in_idx;
  logic [DataW-1:0] plain;
  logic [DataW-1:0] mask;
  logic [5:0]       shl;
  logic [DataW-1:0] merged;
  logic [DataW-1:0] load_word;

  assign in_idx    = byte_addr_i[3 +: IdxW];
  assign is_store  = (cmd_q == CMD_STORE);
  // A store always finishes; a load needs room in the output register.
  assign finish    = busy_q && (is_store || !out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !finish;
  assign in_accept = in_valid_i && !in_stall_o;

  assign plain = fwd_q ? fwd_word_q : (rd_masked_q ^ rd_salt_q);
  assign mask  = width_mask(size_q);
  assign shl   = (size_q == SIZE_DWORD) ? 6'd0 : {off_q, 3'b000};

  always_comb begin
    if (size_q == SIZE_DWORD) begin
      merged = data_q;
    end else begin
      merged = (plain & ~(mask << shl)) | ((data_q & mask) << shl);
    end
  end

  assign load_word = (plain >> shl) & mask;

  // The read that follows a write to the same word would see the old entry.
  assign fwd_d = in_accept && finish && is_store && (in_idx == idx_q);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_masked_q <= masked_mem[in_idx];
    end
    if (finish && is_store) begin
      masked_mem[idx_q] <= merged ^ salt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_salt_q <= salt_mem[in_idx];
    end
    if (finish && is_store) begin
      salt_mem[idx_q] <= salt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= cmd_i;
      idx_q      <= in_idx;
      off_q      <= byte_addr_i[2:0];
      size_q     <= access_size_i;
      data_q     <= write_data_i;
      salt_q     <= fresh_salt_i;
      fwd_word_q <= merged;
    end
    if (finish && !is_store) begin
      read_data_q <= load_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_q <= 1'b1;
        fwd_q  <= fwd_d;
      end else if (finish) begin
        busy_q <= 1'b0;
        fwd_q  <= 1'b0;
      end
      if (finish && !is_store) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

endmodule

/* sv/swm_checker.sv */
// Port-level checker for the salted word memory, bound to the top level.
// It depends on swm_pkg and on the ports of salted_word_memory.
module swm_checker import swm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             cmd_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [DataW-1:0] read_data_o
);

  // A stalled result must stay put until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("stalled result changed or vanished");

  // The input is only held off by a load waiting behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A load taken while the output is empty shows a result after the read stage and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CMD_LOAD) && !out_valid_o |-> ##2 out_valid_o)
    else $error("load produced no result");

endmodule

bind salted_word_memory swm_checker u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);
